// File: rtl/core/rwg_pkg.sv
// Shared types, constants and arithmetic helpers of the reference waveform generator.
package rwg_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int SINE_LOG2  = 10;
	localparam int CFG_IDX_W  = 3;

	localparam int DIV_N_W     = 66;
	localparam int DIV_D_W     = 33;
	localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);
	localparam int POLY_TERMS  = 5;

	localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (DATA_WIDTH - 1)) - 40'sd1;
	localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

	// Taylor terms of sin(pi/2 x) in Q30, highest order first
	localparam logic [30:0] POLY_C [POLY_TERMS] = '{
		31'd172272, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
	};

	typedef enum logic [1:0] {
		WAVE_FIXED    = 2'd0,
		WAVE_SINE     = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_TYPE    = 3'd0,
		REG_AMPLITUDE    = 3'd1,
		REG_DC_LEVEL     = 3'd2,
		REG_FREQUENCY    = 3'd3,
		REG_SAMPLE_PER   = 3'd4,
		REG_DUTY         = 3'd5,
		REG_ANGLE_MODE   = 3'd6,
		REG_ANGLE_PERIOD = 3'd7
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FDT, ST_PHASE, ST_SQ, ST_X2, ST_POLY, ST_SROUND, ST_MODE,
		ST_FIX_STEP, ST_FIX_DIV, ST_SIN_WAVE, ST_SIN_W, ST_SIN_AC,
		ST_WIDE_LO, ST_WIDE_HI, ST_WIDE_SUM, ST_TRI_START, ST_TRI_RAMP, ST_TRI_DM,
		ST_ANG_MUL, ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

	// Q30 argument of the quarter-wave polynomial, folded by quadrant
	function automatic logic [30:0] quarter_x(input logic [31:0] ph);
		logic [30:0] x;
		x = {1'b0, ph[29 -: (SINE_LOG2 - 2)], {(32 - SINE_LOG2){1'b0}}};
		if (ph[30])
			x = 31'h4000_0000 - x;
		return x;
	endfunction

	function automatic logic [31:0] sat_val(input logic signed [39:0] v);
		logic [31:0] r;
		if (v > SAT_HI)
			r = SAT_HI[31:0];
		else if (v < SAT_LO)
			r = SAT_LO[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] from_mag(input logic [79:0] m, input logic neg);
		logic [31:0] r;
		if (m > 80'(SAT_HI))
			r = neg ? SAT_LO[31:0] : SAT_HI[31:0];
		else
			r = neg ? (~m[31:0] + 32'd1) : m[31:0];
		return r;
	endfunction

endpackage

// File: rtl/core/rwg_if.sv
// Handshake channels of the reference waveform generator: tick, result and register write.
interface rwg_in_if;
	logic valid;
	logic ready;
	logic enable;
	modport source(output valid, output enable, input ready);
	modport sink(input valid, input enable, output ready);
endinterface

interface rwg_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_value;
	logic [31:0] out_derivative;
	logic [15:0] sine_value;
	logic [15:0] cosine_value;
	logic [31:0] phase_value;
	modport source(output valid, output out_value, output out_derivative,
		output sine_value, output cosine_value, output phase_value, input ready);
	modport sink(input valid, input out_value, input out_derivative,
		input sine_value, input cosine_value, input phase_value, output ready);
endinterface

interface rwg_cfg_if import rwg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rwg_div.sv
// Restoring divider, one quotient bit per cycle.
module rwg_div import rwg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   num_q, quo_q;
	logic [DIV_D_W-1:0]   den_q, rem_q;
	logic [DIV_D_W:0]     rem_sh;
	logic                 qbit;

	assign rem_sh = {rem_q, num_q[DIV_N_W-1]};
	assign qbit   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_N_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_N_W-2:0], qbit};
			rem_q <= qbit ? DIV_D_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_D_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: rtl/core/reference_waveform_generator_unit.sv
// Reference waveform generator: phase accumulator, sine/cosine and waveform sequencer.
// Usage:
//  cfg    - register writes (index, data); always ready, write only while the block is idle.
//  in_ch  - one word per tick carrying enable; taken only when the sequencer is idle.
//  out_ch - one result word per tick: value, derivative, sine, cosine and phase.
// Each tick runs on one shared 32x32 multiplier, registered after every product,
// and one restoring divider that gives a quotient bit per cycle.
// Divider passes per tick: one for a fixed level with a slew, two for triangle, none otherwise.
// The next tick can be taken in the cycle after the result loads. A result is loaded
// into the output register even while the previous word has just been taken; a tick
// that finishes while the previous word is not yet taken waits in its last state.
// Reset loads the register defaults, clears phase, sine, cosine, ramp and the
// integrator, and empties the output.
module reference_waveform_generator_unit import rwg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	rwg_cfg_if.sink    cfg,
	rwg_in_if.sink     in_ch,
	rwg_out_if.source  out_ch
);

	// registers
	wave_kind_t         type_q;
	logic signed [31:0] amp_q, dc_q;
	logic [31:0]        freq_q, dt_q;
	logic [15:0]        duty_q;
	logic               amode_q;
	logic [30:0]        aper_q;

	// architectural state
	logic [31:0]        phase_q;
	logic signed [15:0] sine_q, cos_q;
	logic signed [31:0] ramp_q, last_out_q, last_der_q;

	// sequencer
	seq_state_t state_q, state_d;
	logic       en_q, sel_q, out_valid_q, fin_load;
	logic [2:0] cnt_q;

	// scratch
	logic [63:0] prod_q, wa_q, lo_q;
	logic [31:0] mul_a, mul_b, fdt_q, wb_q, wave_q, dwave_q;
	logic [30:0] x2_q;
	logic [32:0] denom_q;
	logic        dneg_q, numtop_q;
	logic [31:0] ov_q, od_q, oph_q;
	logic [15:0] os_q, oc_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	rwg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// magnitudes
	logic [31:0] amp_mag, wave_mag;
	logic [15:0] s_mag, c_mag;
	assign amp_mag  = amp_q[31] ? (~unsigned'(amp_q) + 32'd1) : unsigned'(amp_q);
	assign wave_mag = wave_q[31] ? (~wave_q + 32'd1) : wave_q;
	assign s_mag    = sine_q[15] ? (~unsigned'(sine_q) + 16'd1) : unsigned'(sine_q);
	assign c_mag    = cos_q[15] ? (~unsigned'(cos_q) + 16'd1) : unsigned'(cos_q);

	// sine / cosine evaluation
	logic [31:0] sin_ph, rnd;
	logic [30:0] x_arg, poly_t;
	logic [16:0] v17;
	logic [15:0] lim, sv;
	logic        poly_last;
	assign sin_ph    = phase_q + (sel_q ? QUARTER_TURN : 32'd0);
	assign x_arg     = quarter_x(sin_ph);
	assign poly_t    = POLY_C[cnt_q] - prod_q[60:30];
	assign poly_last = cnt_q == 3'(POLY_TERMS - 1);
	assign rnd       = prod_q[61:30] + 32'd16384;
	assign v17       = rnd[31:15];
	assign lim       = (v17 > 17'd32767) ? 16'h7fff : v17[15:0];
	assign sv        = sin_ph[31] ? (~lim + 16'd1) : lim;

	// fixed level slew
	logic signed [33:0] fix_diff, fix_slope, fix_step, fix_new;
	logic [31:0]        fix_mag;
	always_comb begin
		fix_diff  = 34'(dc_q) - 34'(ramp_q);
		fix_slope = signed'({2'b00, prod_q[63:32]});
		fix_step  = fix_diff;
		if (fix_step > fix_slope)
			fix_step = fix_slope;
		if (fix_step < -fix_slope)
			fix_step = -fix_slope;
		fix_new = 34'(ramp_q) + fix_step;
		fix_mag = fix_step[33] ? 32'(-fix_step) : fix_step[31:0];
	end

	// sine and square waveforms
	logic signed [39:0] as_s, sin_sum, sq_sum;
	assign as_s    = signed'({8'd0, prod_q[46:15]});
	assign sin_sum = 40'(dc_q) + ((amp_q[31] ^ sine_q[15]) ? -as_s : as_s);
	assign sq_sum  = (phase_q > {duty_q, 16'd0}) ? 40'(dc_q) - 40'(amp_q)
		: 40'(dc_q) + 40'(amp_q);

	// triangle slopes
	logic [31:0]        duty32;
	logic               lo_half;
	logic [32:0]        base_den, tri_den, tri_num;
	logic signed [39:0] ramp_s, tri_sum;
	logic [DIV_N_W-1:0] tri_div, amp_shl;
	always_comb begin
		duty32   = {duty_q, 16'd0};
		lo_half  = phase_q < duty32;
		base_den = lo_half ? {1'b0, duty32} : (33'h1_0000_0000 - {1'b0, duty32});
		tri_den  = (base_den > {1'b0, fdt_q}) ? base_den : {1'b0, fdt_q};
		tri_num  = lo_half ? {1'b0, phase_q} : (33'h1_0000_0000 - {1'b0, phase_q});
		amp_shl  = {1'b0, amp_mag, 33'd0};
		tri_div  = numtop_q ? amp_shl : {1'b0, prod_q, 1'b0};
		ramp_s   = signed'({7'd0, div_rsp.quotient[32:0]});
		tri_sum  = 40'(dc_q) - 40'(amp_q) + (amp_q[31] ? -ramp_s : ramp_s);
	end

	// wide products and integrator
	logic [95:0]        wide_sum;
	logic signed [35:0] inc_s, a0, a1, a2, per_s;
	logic [31:0]        next_out, next_der;
	assign wide_sum = {32'd0, lo_q} + {prod_q, 32'd0};
	always_comb begin
		inc_s = signed'({4'd0, prod_q[63:32]});
		if (wave_q[31])
			inc_s = -inc_s;
		per_s = signed'({5'd0, aper_q});
		a0    = 36'(last_out_q) + inc_s;
		a1    = (a0 < 36'sd0) ? a0 + per_s : a0;
		a2    = (a1 >= per_s) ? a1 - per_s : a1;
		if (amode_q) begin
			next_out = sat_val(40'(a2));
			next_der = wave_q;
		end else begin
			next_out = wave_q;
			next_der = dwave_q;
		end
	end

	// next state, multiplier operands and divider requests
	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		div_req  = '0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid)
					state_d = ST_FDT;
			end
			ST_FDT: begin
				mul_a   = freq_q;
				mul_b   = dt_q;
				state_d = ST_PHASE;
			end
			ST_PHASE: state_d = ST_SQ;
			ST_SQ: begin
				mul_a   = 32'(x_arg);
				mul_b   = 32'(x_arg);
				state_d = ST_X2;
			end
			ST_X2: begin
				mul_a   = 32'(POLY_C[0]);
				mul_b   = 32'(prod_q[60:30]);
				state_d = ST_POLY;
			end
			ST_POLY: begin
				mul_a = 32'(poly_t);
				mul_b = poly_last ? 32'(x_arg) : 32'(x2_q);
				if (poly_last)
					state_d = ST_SROUND;
			end
			ST_SROUND: state_d = sel_q ? ST_MODE : ST_SQ;
			ST_MODE: begin
				state_d = ST_ANG_MUL;
				if (en_q) begin
					case (type_q)
						WAVE_FIXED: begin
							if (!amp_q[31] && amp_q != 32'sd0) begin
								mul_a   = amp_q;
								mul_b   = fdt_q;
								state_d = ST_FIX_STEP;
							end
						end
						WAVE_SINE: begin
							mul_a   = amp_mag;
							mul_b   = 32'(s_mag);
							state_d = ST_SIN_WAVE;
						end
						WAVE_TRIANGLE: begin
							mul_a   = amp_mag;
							mul_b   = tri_num[31:0];
							state_d = ST_TRI_START;
						end
						default: state_d = ST_ANG_MUL;
					endcase
				end
			end
			ST_FIX_STEP: begin
				if (fix_step == 34'sd0 || dt_q == 32'd0) begin
					state_d = ST_ANG_MUL;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {2'b00, fix_mag, 32'd0};
					div_req.divisor  = {1'b0, dt_q};
					state_d          = ST_FIX_DIV;
				end
			end
			ST_FIX_DIV: begin
				if (div_rsp.done)
					state_d = ST_ANG_MUL;
			end
			ST_SIN_WAVE: begin
				mul_a   = freq_q;
				mul_b   = TWO_PI_Q29;
				state_d = ST_SIN_W;
			end
			ST_SIN_W: begin
				mul_a   = amp_mag;
				mul_b   = 32'(c_mag);
				state_d = ST_SIN_AC;
			end
			ST_SIN_AC: state_d = ST_WIDE_LO;
			ST_WIDE_LO: begin
				mul_a   = wa_q[31:0];
				mul_b   = wb_q;
				state_d = ST_WIDE_HI;
			end
			ST_WIDE_HI: begin
				mul_a   = wa_q[63:32];
				mul_b   = wb_q;
				state_d = ST_WIDE_SUM;
			end
			ST_WIDE_SUM: state_d = ST_ANG_MUL;
			ST_TRI_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = tri_div;
				div_req.divisor  = denom_q;
				state_d          = ST_TRI_RAMP;
			end
			ST_TRI_RAMP: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = amp_shl;
					div_req.divisor  = denom_q;
					state_d          = ST_TRI_DM;
				end
			end
			ST_TRI_DM: begin
				if (div_rsp.done)
					state_d = ST_WIDE_LO;
			end
			ST_ANG_MUL: begin
				mul_a   = wave_mag;
				mul_b   = dt_q;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// keep the increment product in place while the output word waits
				mul_a = wave_mag;
				mul_b = dt_q;
				if (!out_valid_q || out_ch.ready) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// registers, architectural state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q      <= WAVE_SINE;
			amp_q       <= '0;
			dc_q        <= '0;
			freq_q      <= '0;
			dt_q        <= 32'd214748;
			duty_q      <= 16'd32768;
			amode_q     <= 1'b0;
			aper_q      <= 31'd65536;
			phase_q     <= '0;
			sine_q      <= '0;
			cos_q       <= '0;
			ramp_q      <= '0;
			last_out_q  <= '0;
			last_der_q  <= '0;
			en_q        <= 1'b0;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_WAVE_TYPE:    type_q  <= wave_kind_t'(cfg.data[1:0]);
					REG_AMPLITUDE:    amp_q   <= signed'(cfg.data);
					REG_DC_LEVEL:     dc_q    <= signed'(cfg.data);
					REG_FREQUENCY:    freq_q  <= cfg.data;
					REG_SAMPLE_PER:   dt_q    <= cfg.data;
					REG_DUTY:         duty_q  <= cfg.data[15:0];
					REG_ANGLE_MODE:   amode_q <= cfg.data[0];
					REG_ANGLE_PERIOD: aper_q  <= cfg.data[30:0];
				endcase
			end
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid)
						en_q <= in_ch.enable;
				end
				ST_PHASE: begin
					phase_q <= phase_q + prod_q[47:16];
					sel_q   <= 1'b0;
				end
				ST_X2: cnt_q <= 3'd1;
				ST_POLY: cnt_q <= cnt_q + 3'd1;
				ST_SROUND: begin
					if (sel_q) begin
						cos_q <= signed'(sv);
					end else begin
						sine_q <= signed'(sv);
						sel_q  <= 1'b1;
					end
				end
				ST_MODE: begin
					if (!en_q) begin
						phase_q <= '0;
						ramp_q  <= '0;
					end else if (type_q == WAVE_FIXED && (amp_q[31] || amp_q == 32'sd0)) begin
						ramp_q <= dc_q;
					end
				end
				ST_FIX_STEP: ramp_q <= fix_new[31:0];
				ST_FINISH: begin
					if (fin_load) begin
						last_out_q <= signed'(next_out);
						last_der_q <= signed'(next_der);
					end
				end
				default: ;
			endcase
		end
	end

	// scratch and output word
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			ST_PHASE: fdt_q <= (|prod_q[63:48]) ? '1 : prod_q[47:16];
			ST_X2: x2_q <= prod_q[60:30];
			ST_MODE: begin
				wave_q  <= '0;
				dwave_q <= '0;
				if (en_q) begin
					case (type_q)
						WAVE_FIXED:  wave_q <= dc_q;
						WAVE_SQUARE: wave_q <= sat_val(sq_sum);
						WAVE_TRIANGLE: begin
							denom_q  <= tri_den;
							numtop_q <= tri_num[32];
							dneg_q   <= lo_half ? amp_q[31] : !amp_q[31];
						end
						default: ;
					endcase
				end
			end
			ST_FIX_STEP: begin
				wave_q <= fix_new[31:0];
				dneg_q <= fix_step[33];
				if (fix_step == 34'sd0)
					dwave_q <= '0;
				else
					dwave_q <= from_mag('1, fix_step[33]);
			end
			ST_FIX_DIV: begin
				if (div_rsp.done)
					dwave_q <= from_mag(80'(div_rsp.quotient), dneg_q);
			end
			ST_SIN_WAVE: wave_q <= sat_val(sin_sum);
			ST_SIN_W: wa_q <= {29'd0, prod_q[63:29]};
			ST_SIN_AC: begin
				wb_q   <= prod_q[46:15];
				dneg_q <= amp_q[31] ^ cos_q[15];
			end
			ST_WIDE_HI: lo_q <= prod_q;
			ST_WIDE_SUM: dwave_q <= from_mag(wide_sum[95:16], dneg_q);
			ST_TRI_RAMP: begin
				if (div_rsp.done)
					wave_q <= sat_val(tri_sum);
			end
			ST_TRI_DM: begin
				if (div_rsp.done) begin
					// quotient beyond 64 bits saturates
					wa_q <= (|div_rsp.quotient[DIV_N_W-1:64]) ? '1 : div_rsp.quotient[63:0];
					wb_q <= freq_q;
				end
			end
			ST_FINISH: begin
				if (fin_load) begin
					ov_q  <= next_out;
					od_q  <= next_der;
					os_q  <= sine_q;
					oc_q  <= cos_q;
					oph_q <= phase_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = state_q == ST_IDLE;

	assign out_ch.valid          = out_valid_q;
	assign out_ch.out_value      = ov_q;
	assign out_ch.out_derivative = od_q;
	assign out_ch.sine_value     = os_q;
	assign out_ch.cosine_value   = oc_q;
	assign out_ch.phase_value    = oph_q;

endmodule
